// ===== rtl/sct_pkg.sv =====
// Shared constants, types and the color range remap for the skin color translate scaler.
// No dependencies; the other files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package sct_pkg;

  localparam int TEXEL_DEPTH   = 131072;
  localparam int TEXEL_AW      = $clog2(TEXEL_DEPTH);
  localparam int PALETTE_DEPTH = 256;
  localparam int PALETTE_AW    = $clog2(PALETTE_DEPTH);

  localparam logic [7:0] TOP_RANGE_BASE    = 8'd16;
  localparam logic [7:0] BOTTOM_RANGE_BASE = 8'd96;
  localparam logic [7:0] RANGE_SIZE        = 8'd16;
  localparam logic [7:0] RANGE_LAST        = 8'd15;
  localparam logic [7:0] FULLBRIGHT_FIRST  = 8'd224;
  localparam logic [31:0] RGB_MASK         = 32'h00FF_FFFF;

  localparam int OP_W    = 2;
  localparam int ADDR_W  = 17;
  localparam int WORD_W  = 32;
  localparam int TEXEL_W = 8;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 4;
  localparam int SRC_W   = 11;
  localparam int TGTW_W  = 10;
  localparam int TGTH_W  = 9;

  localparam logic [OP_W-1:0] OP_LOAD_PALETTE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TEXEL   = 2'd1;
  localparam logic [OP_W-1:0] OP_RENDER       = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_COLOR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_COLOR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FULLBRIGHT    = 3'd6;

  // Column step is 11.16 fixed point; rows use a reciprocal of the target height.
  localparam int FRAC_W      = 16;
  localparam int STEP_W      = SRC_W + FRAC_W;
  localparam int NUMER_W     = Y_W + SRC_W;
  localparam int RECIP_SHIFT = NUMER_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int XS_W        = X_W + STEP_W;
  localparam int COL_W       = XS_W - FRAC_W;
  localparam int ROW_W       = RECIP_W;
  localparam int PROD_W      = NUMER_W + RECIP_W;
  localparam int QD_W        = ROW_W + TGTH_W;
  localparam int LIN_W       = 32;

  localparam int DIV_NW = STEP_W;
  localparam int DIV_DW = TGTW_W;
  localparam int DIV_CW = $clog2(DIV_NW);
  localparam logic [DIV_NW-1:0] RECIP_NUM = DIV_NW'(1) << RECIP_SHIFT;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  function automatic logic [7:0] translate_index(logic [7:0] v, logic [COLOR_W-1:0] top,
                                                 logic [COLOR_W-1:0] bottom);
    logic [7:0] tb;
    logic [7:0] bb;
    logic [7:0] ot;
    logic [7:0] ob;
    logic [7:0] res;
    tb = {top, 4'h0};
    bb = {bottom, 4'h0};
    ot = v - TOP_RANGE_BASE;
    ob = v - BOTTOM_RANGE_BASE;
    if (v >= BOTTOM_RANGE_BASE &&
        {1'b0, v} < {1'b0, BOTTOM_RANGE_BASE} + {1'b0, RANGE_SIZE}) begin
      res = bb[7] ? bb + RANGE_LAST - ob : bb + ob;
    end else if (v >= TOP_RANGE_BASE &&
                 {1'b0, v} < {1'b0, TOP_RANGE_BASE} + {1'b0, RANGE_SIZE}) begin
      res = tb[7] ? tb + RANGE_LAST - ot : tb + ot;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== rtl/sct_if.sv =====
// Valid/ready channel interfaces: command words in, pixel words out, register writes.
// Depends on sct_pkg for field widths.
`timescale 1ns / 1ps

interface sct_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [sct_pkg::OP_W-1:0]     operation;
  logic [sct_pkg::ADDR_W-1:0]   load_address;
  logic [sct_pkg::WORD_W-1:0]   palette_word;
  logic [sct_pkg::TEXEL_W-1:0]  texel_value;
  logic [sct_pkg::X_W-1:0]      pixel_x;
  logic [sct_pkg::Y_W-1:0]      pixel_y;

  modport source (output valid, operation, load_address, palette_word, texel_value,
                  pixel_x, pixel_y, input ready);
  modport sink (input valid, operation, load_address, palette_word, texel_value,
                pixel_x, pixel_y, output ready);
endinterface

interface sct_pix_if;
  logic                        valid;
  logic                        ready;
  logic [sct_pkg::IDX_W-1:0]   translated_index;
  logic [sct_pkg::WORD_W-1:0]  pixel_rgba;

  modport source (output valid, translated_index, pixel_rgba, input ready);
  modport sink (input valid, translated_index, pixel_rgba, output ready);
endinterface

interface sct_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sct_pkg::CFG_IDX_W-1:0]  index;
  logic [sct_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/sct_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No package dependency.
`timescale 1ns / 1ps

module sct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sct_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, for the setup pass.
// Depends on sct_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module sct_div (
  input  logic              clk,
  input  logic              rst,
  input  sct_pkg::div_req_t req,
  output sct_pkg::div_rsp_t rsp
);

  logic [sct_pkg::DIV_NW-1:0] quo;
  logic [sct_pkg::DIV_DW-1:0] rem;
  logic [sct_pkg::DIV_DW-1:0] den;
  logic [sct_pkg::DIV_CW-1:0] cnt;
  logic                       run;
  logic                       done;
  logic [sct_pkg::DIV_DW:0]   trial;
  logic [sct_pkg::DIV_DW:0]   diff;
  logic                       ge;

  assign trial = {rem, quo[sct_pkg::DIV_NW-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == '0);
      if (req.start) begin
        run <= 1'b1;
      end else if (run && cnt == '0) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
      den <= req.den;
      cnt <= sct_pkg::DIV_CW'(sct_pkg::DIV_NW - 1);
    end else if (run) begin
      rem <= ge ? diff[sct_pkg::DIV_DW-1:0] : trial[sct_pkg::DIV_DW-1:0];
      quo <= {quo[sct_pkg::DIV_NW-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

// ===== rtl/skin_color_translate_scaler.sv =====
// Top level: registers, setup divider sequencer, seven-stage sampling pipeline, output word.
// Depends on sct_pkg, sct_if, sct_ram and sct_div.
//
//   channel | role           | word
//   cmd     | sink           | operation, load_address, palette_word, texel_value, x, y
//   pixel   | source         | translated_index, pixel_rgba
//   cfg     | sink, write    | index, data (always ready)
//
// One command word per cycle unless setup or a stall holds cmd.ready low; a render word
// goes through stages 1 to 7 and the output register. Loads pass down the same pipeline
// and write the texel or palette RAM at the stage where renders read it, so results
// follow command order. After reset and after any register write, cmd.ready stays low
// while the shared divider forms the column step and the row reciprocal.
// A stage holds if the next is full and held; the output register holds while stalled.
`timescale 1ns / 1ps

module skin_color_translate_scaler (
  input logic        clk,
  input logic        rst,
  sct_cmd_if.sink    cmd,
  sct_pix_if.source  pixel,
  sct_cfg_if.sink    cfg
);

  localparam logic [1:0] SU_IDLE  = 2'd0;
  localparam logic [1:0] SU_STEP  = 2'd1;
  localparam logic [1:0] SU_RECIP = 2'd2;

  typedef struct packed {
    logic [sct_pkg::OP_W-1:0]    op;
    logic [sct_pkg::ADDR_W-1:0]  addr;
    logic [sct_pkg::WORD_W-1:0]  pword;
    logic [sct_pkg::TEXEL_W-1:0] tval;
  } item_t;

  // registers
  logic [sct_pkg::COLOR_W-1:0] top_color;
  logic [sct_pkg::COLOR_W-1:0] bottom_color;
  logic [sct_pkg::SRC_W-1:0]   source_width;
  logic [sct_pkg::SRC_W-1:0]   source_height;
  logic [sct_pkg::TGTW_W-1:0]  target_width;
  logic [sct_pkg::TGTH_W-1:0]  target_height;
  logic                        fullbright_pass;
  logic                        cfg_wr;

  logic [sct_pkg::TGTW_W-1:0]  tw_eff;
  logic [sct_pkg::TGTH_W-1:0]  th_eff;

  // setup
  logic [1:0]                   state;
  logic                         pending;
  logic                         busy;
  logic [sct_pkg::STEP_W-1:0]   step;
  logic [sct_pkg::RECIP_W-1:0]  recip;
  sct_pkg::div_req_t            div_req;
  sct_pkg::div_rsp_t            div_rsp;

  // pipeline
  logic [7:1] v;
  logic [7:1] rdy;
  item_t      it [1:7];
  logic       out_free;
  logic       cmd_acc;
  logic       cmd_live;

  logic [sct_pkg::NUMER_W-1:0] n1, n2, n3;
  logic [sct_pkg::XS_W-1:0]    xs1;
  logic [sct_pkg::XS_W-1:0]    col_sum;
  logic [sct_pkg::PROD_W-1:0]  prod;
  logic [sct_pkg::ROW_W-1:0]   q02, q03, row4;
  logic [sct_pkg::COL_W-1:0]   col2, col3, col4;
  logic [sct_pkg::QD_W-1:0]    qd3;
  logic [sct_pkg::QD_W-1:0]    rem4;
  logic [sct_pkg::LIN_W-1:0]   lin5;
  logic                        inr5;
  logic                        oor6;
  logic                        pal_ok6;
  logic [sct_pkg::PALETTE_AW-1:0] pal_addr6;
  logic [sct_pkg::TEXEL_W-1:0] tex_q;
  logic [sct_pkg::TEXEL_W-1:0] src6;
  logic [sct_pkg::IDX_W-1:0]   idx6;
  logic [sct_pkg::IDX_W-1:0]   idx7;
  logic                        clr7;
  logic [sct_pkg::WORD_W-1:0]  pal_q;
  logic                        tex_we;
  logic                        pal_we;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_color       <= '0;
      bottom_color    <= '0;
      source_width    <= sct_pkg::SRC_W'(1);
      source_height   <= sct_pkg::SRC_W'(1);
      target_width    <= sct_pkg::TGTW_W'(1);
      target_height   <= sct_pkg::TGTH_W'(1);
      fullbright_pass <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        sct_pkg::REG_TOP_COLOR:     top_color       <= cfg.data[sct_pkg::COLOR_W-1:0];
        sct_pkg::REG_BOTTOM_COLOR:  bottom_color    <= cfg.data[sct_pkg::COLOR_W-1:0];
        sct_pkg::REG_SOURCE_WIDTH:  source_width    <= cfg.data[sct_pkg::SRC_W-1:0];
        sct_pkg::REG_SOURCE_HEIGHT: source_height   <= cfg.data[sct_pkg::SRC_W-1:0];
        sct_pkg::REG_TARGET_WIDTH:  target_width    <= cfg.data[sct_pkg::TGTW_W-1:0];
        sct_pkg::REG_TARGET_HEIGHT: target_height   <= cfg.data[sct_pkg::TGTH_W-1:0];
        sct_pkg::REG_FULLBRIGHT:    fullbright_pass <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign tw_eff = (target_width == '0) ? sct_pkg::TGTW_W'(1) : target_width;
  assign th_eff = (target_height == '0) ? sct_pkg::TGTH_W'(1) : target_height;

  // setup: step = (source_width << 16) / tw, recip = 2^RECIP_SHIFT / th
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = {source_width, sct_pkg::FRAC_W'(0)};
    div_req.den   = tw_eff;
    if (state == SU_IDLE && pending) begin
      div_req.start = 1'b1;
    end else if (state == SU_STEP && div_rsp.done) begin
      div_req.start = 1'b1;
      div_req.num   = sct_pkg::RECIP_NUM;
      div_req.den   = sct_pkg::DIV_DW'(th_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= SU_IDLE;
      pending <= 1'b1;
    end else begin
      unique case (state)
        SU_IDLE: begin
          if (pending) begin
            state   <= SU_STEP;
            pending <= 1'b0;
          end
        end
        SU_STEP: begin
          if (div_rsp.done) begin
            step  <= div_rsp.quo;
            state <= SU_RECIP;
          end
        end
        SU_RECIP: begin
          if (div_rsp.done) begin
            recip <= div_rsp.quo[sct_pkg::RECIP_W-1:0];
            state <= SU_IDLE;
          end
        end
        default: state <= SU_IDLE;
      endcase
      if (cfg_wr) begin
        pending <= 1'b1;
      end
    end
  end

  assign busy = pending || (state != SU_IDLE);

  sct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // handshake chain
  assign out_free = !pixel.valid || pixel.ready;

  always_comb begin
    rdy[7] = !v[7] || out_free || (it[7].op != sct_pkg::OP_RENDER);
    for (int k = 6; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign cmd.ready = rdy[1] && !busy;
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign cmd_live  = (cmd.operation == sct_pkg::OP_LOAD_PALETTE) ||
                     (cmd.operation == sct_pkg::OP_LOAD_TEXEL) ||
                     (cmd.operation == sct_pkg::OP_RENDER);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) begin
        v[1] <= cmd_acc && cmd_live;
      end
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      it[1] <= '{op: cmd.operation, addr: cmd.load_address, pword: cmd.palette_word,
                 tval: cmd.texel_value};
    end
    for (int k = 2; k <= 7; k++) begin
      if (rdy[k]) begin
        it[k] <= it[k-1];
      end
    end
  end

  // stage 1: y * source_height, x * step
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      n1  <= sct_pkg::NUMER_W'(cmd.pixel_y) * sct_pkg::NUMER_W'(source_height);
      xs1 <= sct_pkg::XS_W'(cmd.pixel_x) * sct_pkg::XS_W'(step);
    end
  end

  // stage 2: row estimate by reciprocal, column with half step
  assign prod    = sct_pkg::PROD_W'(n1) * sct_pkg::PROD_W'(recip);
  assign col_sum = xs1 + sct_pkg::XS_W'(step >> 1);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      n2   <= n1;
      q02  <= prod[sct_pkg::RECIP_SHIFT +: sct_pkg::ROW_W];
      col2 <= col_sum[sct_pkg::FRAC_W +: sct_pkg::COL_W];
    end
  end

  // stage 3: estimate times divisor
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      n3   <= n2;
      q03  <= q02;
      col3 <= col2;
      qd3  <= sct_pkg::QD_W'(q02) * sct_pkg::QD_W'(th_eff);
    end
  end

  // stage 4: correct estimate by one
  assign rem4 = sct_pkg::QD_W'(n3) - qd3;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      row4 <= (rem4 >= sct_pkg::QD_W'(th_eff)) ? q03 + 1'b1 : q03;
      col4 <= col3;
    end
  end

  // stage 5: linear address, or load address
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      if (it[4].op == sct_pkg::OP_RENDER) begin
        lin5 <= sct_pkg::LIN_W'(row4) * sct_pkg::LIN_W'(source_width) +
                sct_pkg::LIN_W'(col4);
      end else begin
        lin5 <= sct_pkg::LIN_W'(it[4].addr);
      end
    end
  end

  assign inr5   = lin5 < sct_pkg::LIN_W'(sct_pkg::TEXEL_DEPTH);
  assign tex_we = rdy[6] && v[5] && (it[5].op == sct_pkg::OP_LOAD_TEXEL) && inr5;

  sct_ram #(
    .WIDTH (sct_pkg::TEXEL_W),
    .DEPTH (sct_pkg::TEXEL_DEPTH)
  ) u_texel_ram (
    .clk   (clk),
    .we    (tex_we),
    .waddr (lin5[sct_pkg::TEXEL_AW-1:0]),
    .wdata (it[5].tval),
    .re    (rdy[6]),
    .raddr (lin5[sct_pkg::TEXEL_AW-1:0]),
    .rdata (tex_q)
  );

  // stage 6: texel out of RAM, remap, palette access
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      oor6      <= !inr5;
      pal_ok6   <= lin5 < sct_pkg::LIN_W'(sct_pkg::PALETTE_DEPTH);
      pal_addr6 <= lin5[sct_pkg::PALETTE_AW-1:0];
    end
  end

  assign src6   = oor6 ? '0 : tex_q;
  assign idx6   = sct_pkg::translate_index(src6, top_color, bottom_color);
  assign pal_we = rdy[7] && v[6] && (it[6].op == sct_pkg::OP_LOAD_PALETTE) && pal_ok6;

  sct_ram #(
    .WIDTH (sct_pkg::WORD_W),
    .DEPTH (sct_pkg::PALETTE_DEPTH)
  ) u_palette_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_addr6),
    .wdata (it[6].pword),
    .re    (rdy[7]),
    .raddr (idx6),
    .rdata (pal_q)
  );

  // stage 7: palette word out of RAM, alpha clear, output word
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      idx7 <= idx6;
      clr7 <= fullbright_pass && (src6 < sct_pkg::FULLBRIGHT_FIRST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
    end else if (out_free) begin
      pixel.valid <= v[7] && (it[7].op == sct_pkg::OP_RENDER);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v[7] && it[7].op == sct_pkg::OP_RENDER) begin
      pixel.translated_index <= idx7;
      pixel.pixel_rgba       <= clr7 ? (pal_q & sct_pkg::RGB_MASK) : pal_q;
    end
  end

endmodule

// ===== rtl/sct_check.sv =====
// Port-level checker for the skin color translate scaler, bound to the top level.
// Depends on sct_pkg for widths.
`timescale 1ns / 1ps

module sct_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        cmd_ready,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic                        pix_valid,
  input logic                        pix_ready,
  input logic [sct_pkg::IDX_W-1:0]   pix_index,
  input logic [sct_pkg::WORD_W-1:0]  pix_rgba
);

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid)
    else $error("pixel word dropped while stalled");

  a_pix_stable: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> $stable(pix_index) && $stable(pix_rgba))
    else $error("pixel word changed while stalled");

  a_cfg_setup: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !cmd_ready)
    else $error("command taken before setup after register write");

  a_reset: assert property (@(posedge clk)
    rst |=> !pix_valid && !cmd_ready)
    else $error("reset left output valid or command ready");

endmodule

bind skin_color_translate_scaler sct_check u_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .cfg_valid (cfg.valid),
  .cfg_ready (cfg.ready),
  .pix_valid (pixel.valid),
  .pix_ready (pixel.ready),
  .pix_index (pixel.translated_index),
  .pix_rgba  (pixel.pixel_rgba)
);

// ===== tb/sv/tb_skin_color_translate_scaler.sv =====
// Testbench for skin_color_translate_scaler: loads palette and texels, renders scaled and
// recolored pixels under many register settings, and checks every pixel word in order.
// Depends on sct_pkg, sct_if and the block's RTL.
`timescale 1ns / 1ps

module tb_skin_color_translate_scaler;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 24;
  localparam logic [sct_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [sct_pkg::OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [7:0] SHADES [8] = '{8'd0, 8'd16, 8'd31, 8'd96, 8'd111, 8'd223, 8'd224,
                                        8'd255};

  typedef struct packed {
    logic [sct_pkg::IDX_W-1:0]  index;
    logic [sct_pkg::WORD_W-1:0] rgba;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;

  sct_cmd_if cmd_ch ();
  sct_pix_if pix_ch ();
  sct_cfg_if cfg_ch ();

  assign pix_ch.ready = sink_ready;

  skin_color_translate_scaler dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_ch),
    .pixel (pix_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_word_t                 pending_pixels[$];
  pixel_word_t                 oldest_pixel;
  logic [sct_pkg::WORD_W-1:0]  palette_mem [sct_pkg::PALETTE_DEPTH];
  logic [sct_pkg::TEXEL_W-1:0] texel_mem [sct_pkg::TEXEL_DEPTH];
  bit                          texel_loaded [sct_pkg::TEXEL_DEPTH];

  logic [sct_pkg::COLOR_W-1:0] top_q       = '0;
  logic [sct_pkg::COLOR_W-1:0] bottom_q    = '0;
  logic [sct_pkg::SRC_W-1:0]   src_w_q     = 11'd1;
  logic [sct_pkg::SRC_W-1:0]   src_h_q     = 11'd1;
  logic [sct_pkg::TGTW_W-1:0]  tgt_w_q     = 10'd1;
  logic [sct_pkg::TGTH_W-1:0]  tgt_h_q     = 9'd1;
  logic                        fullbright_q = 1'b0;

  bit quiet = 1'b0;
  int err_count = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] range_pick(int base, int off);
    if (base < 128) return 8'(base + off);
    return 8'(base + int'(sct_pkg::RANGE_LAST) - off);
  endfunction

  function automatic logic [7:0] remap_index(logic [7:0] v);
    int vi;
    int top_base;
    int bottom_base;
    vi = v;
    top_base = int'(top_q) * 16;
    bottom_base = int'(bottom_q) * 16;
    if (vi >= int'(sct_pkg::BOTTOM_RANGE_BASE) &&
        vi < int'(sct_pkg::BOTTOM_RANGE_BASE) + int'(sct_pkg::RANGE_SIZE))
      return range_pick(bottom_base, vi - int'(sct_pkg::BOTTOM_RANGE_BASE));
    if (vi >= int'(sct_pkg::TOP_RANGE_BASE) &&
        vi < int'(sct_pkg::TOP_RANGE_BASE) + int'(sct_pkg::RANGE_SIZE))
      return range_pick(top_base, vi - int'(sct_pkg::TOP_RANGE_BASE));
    return v;
  endfunction

  function automatic longint unsigned texel_address(longint unsigned x, longint unsigned y);
    longint unsigned sw;
    longint unsigned sh;
    longint unsigned tw;
    longint unsigned th;
    longint unsigned step;
    longint unsigned col;
    longint unsigned row;
    sw = src_w_q;
    sh = src_h_q;
    tw = (tgt_w_q == 0) ? 1 : tgt_w_q;
    th = (tgt_h_q == 0) ? 1 : tgt_h_q;
    step = (sw << sct_pkg::FRAC_W) / tw;
    col = ((step >> 1) + x * step) >> sct_pkg::FRAC_W;
    row = (y * sh) / th;
    return row * sw + col;
  endfunction

  function automatic pixel_word_t predict_pixel(longint unsigned x, longint unsigned y);
    longint unsigned lin;
    logic [7:0] src;
    pixel_word_t w;
    lin = texel_address(x, y);
    src = (lin < sct_pkg::TEXEL_DEPTH) ? texel_mem[lin[sct_pkg::TEXEL_AW-1:0]] : 8'd0;
    w.index = remap_index(src);
    w.rgba = palette_mem[w.index];
    if (fullbright_q && src < sct_pkg::FULLBRIGHT_FIRST) w.rgba = w.rgba & sct_pkg::RGB_MASK;
    return w;
  endfunction

  task automatic send_word(input logic [sct_pkg::OP_W-1:0] op,
                           input logic [sct_pkg::ADDR_W-1:0] addr,
                           input logic [sct_pkg::WORD_W-1:0] word,
                           input logic [sct_pkg::TEXEL_W-1:0] texel,
                           input logic [sct_pkg::X_W-1:0] x,
                           input logic [sct_pkg::Y_W-1:0] y);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.load_address <= addr;
    cmd_ch.palette_word <= word;
    cmd_ch.texel_value <= texel;
    cmd_ch.pixel_x <= x;
    cmd_ch.pixel_y <= y;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    case (op)
      sct_pkg::OP_LOAD_PALETTE: begin
        if (addr < sct_pkg::PALETTE_DEPTH) palette_mem[addr[sct_pkg::PALETTE_AW-1:0]] = word;
      end
      sct_pkg::OP_LOAD_TEXEL: begin
        if (addr < sct_pkg::TEXEL_DEPTH) begin
          texel_mem[addr] = texel;
          texel_loaded[addr] = 1'b1;
        end
      end
      sct_pkg::OP_RENDER: pending_pixels.push_back(predict_pixel(x, y));
      default: ;
    endcase
  endtask

  task automatic render_pixel(input logic [sct_pkg::X_W-1:0] x,
                              input logic [sct_pkg::Y_W-1:0] y);
    longint unsigned lin;
    lin = texel_address(x, y);
    if (lin < sct_pkg::TEXEL_DEPTH && !texel_loaded[lin[sct_pkg::TEXEL_AW-1:0]])
      send_word(sct_pkg::OP_LOAD_TEXEL, lin[sct_pkg::ADDR_W-1:0], $urandom, 8'($urandom),
                9'($urandom), 8'($urandom));
    send_word(sct_pkg::OP_RENDER, 17'($urandom), $urandom, 8'($urandom), x, y);
  endtask

  task automatic load_texel(input logic [sct_pkg::ADDR_W-1:0] addr,
                            input logic [sct_pkg::TEXEL_W-1:0] value);
    send_word(sct_pkg::OP_LOAD_TEXEL, addr, $urandom, value, 9'($urandom), 8'($urandom));
  endtask

  task automatic load_palette(input logic [sct_pkg::ADDR_W-1:0] addr,
                              input logic [sct_pkg::WORD_W-1:0] word);
    send_word(sct_pkg::OP_LOAD_PALETTE, addr, word, 8'($urandom), 9'($urandom),
              8'($urandom));
  endtask

  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic write_reg(input logic [sct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sct_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      sct_pkg::REG_TOP_COLOR:     top_q = data[sct_pkg::COLOR_W-1:0];
      sct_pkg::REG_BOTTOM_COLOR:  bottom_q = data[sct_pkg::COLOR_W-1:0];
      sct_pkg::REG_SOURCE_WIDTH:  src_w_q = data[sct_pkg::SRC_W-1:0];
      sct_pkg::REG_SOURCE_HEIGHT: src_h_q = data[sct_pkg::SRC_W-1:0];
      sct_pkg::REG_TARGET_WIDTH:  tgt_w_q = data[sct_pkg::TGTW_W-1:0];
      sct_pkg::REG_TARGET_HEIGHT: tgt_h_q = data[sct_pkg::TGTH_W-1:0];
      sct_pkg::REG_FULLBRIGHT:    fullbright_q = data[0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int top, input int bottom, input int sw, input int sh,
                            input int tw, input int th, input int fb);
    wait_idle();
    write_reg(sct_pkg::REG_TOP_COLOR, 11'(top));
    write_reg(sct_pkg::REG_BOTTOM_COLOR, 11'(bottom));
    write_reg(sct_pkg::REG_SOURCE_WIDTH, 11'(sw));
    write_reg(sct_pkg::REG_SOURCE_HEIGHT, 11'(sh));
    write_reg(sct_pkg::REG_TARGET_WIDTH, 11'(tw));
    write_reg(sct_pkg::REG_TARGET_HEIGHT, 11'(th));
    write_reg(sct_pkg::REG_FULLBRIGHT, 11'(fb));
  endtask

  task automatic test_reset_defaults();
    for (int i = 0; i < sct_pkg::PALETTE_DEPTH; i++) begin
      if (i == 0) load_palette(17'(i), 32'h0000_0000);
      else if (i == 255) load_palette(17'(i), 32'hFFFF_FFFF);
      else load_palette(17'(i), $urandom);
    end
    // out-of-range palette loads must leave the palette alone
    load_palette(17'd256, 32'hDEAD_BEEF);
    load_palette(17'h1FFFF, 32'h1234_5678);
    load_texel(17'd0, 8'd0);
    load_texel(17'h1FFFF, 8'hFF);
    render_pixel(9'd0, 8'd0);
    send_word(OP_UNUSED, 17'h1FFFF, 32'hFFFF_FFFF, 8'hFF, 9'h1FF, 8'hFF);
    render_pixel(9'd511, 8'd255);
  endtask

  task automatic test_color_ranges();
    set_config(0, 15, 16, 16, 16, 16, 1);
    for (int i = 0; i < 8; i++) load_texel(17'(i), SHADES[i]);
    for (int i = 0; i < 8; i++) render_pixel(9'(i), 8'd0);
    set_config(8, 7, 16, 16, 16, 16, 0);
    write_reg(REG_UNUSED, 11'h7FF);
    for (int i = 1; i < 5; i++) render_pixel(9'(i), 8'd0);
  endtask

  task automatic test_scaling_extremes();
    set_config(3, 12, 1024, 1024, 1, 1, 0);
    render_pixel(9'd0, 8'd0);
    render_pixel(9'd1, 8'd1);
    render_pixel(9'd511, 8'd255);
    set_config(15, 0, 1, 1, 512, 256, 1);
    render_pixel(9'd511, 8'd255);
    render_pixel(9'd0, 8'd0);
    // zero target size acts as one
    set_config(1, 6, 37, 5, 0, 0, 0);
    render_pixel(9'd3, 8'd2);
    // zero source size samples the first texel
    set_config(6, 1, 0, 0, 7, 3, 1);
    render_pixel(9'd100, 8'd200);
    // column far past the row end leaves the texel RAM and samples zero
    set_config(9, 10, 1000, 3, 3, 256, 0);
    render_pixel(9'd511, 8'd17);
  endtask

  task automatic test_random_traffic(input int items, input bit with_hold);
    int r;
    int sw;
    int sh;
    int tw;
    int th;
    longint unsigned area;
    logic [sct_pkg::X_W-1:0] x;
    logic [sct_pkg::Y_W-1:0] y;
    logic [sct_pkg::ADDR_W-1:0] addr;
    r = $urandom_range(0, 9);
    sw = (r < 8) ? $urandom_range(1, 32) : (r == 8) ? 1024 : $urandom_range(0, 1024);
    r = $urandom_range(0, 9);
    sh = (r < 8) ? $urandom_range(1, 32) : (r == 8) ? 1024 : $urandom_range(0, 1024);
    r = $urandom_range(0, 9);
    tw = (r < 8) ? $urandom_range(1, 48) : (r == 8) ? 512 : $urandom_range(0, 512);
    r = $urandom_range(0, 9);
    th = (r < 8) ? $urandom_range(1, 48) : (r == 8) ? 256 : $urandom_range(0, 256);
    set_config($urandom_range(0, 15), $urandom_range(0, 15), sw, sh, tw, th,
               $urandom_range(0, 1));
    area = longint'(sw) * longint'(sh);
    if (area > sct_pkg::TEXEL_DEPTH) area = sct_pkg::TEXEL_DEPTH;
    for (int n = 0; n < items; n++) begin
      if (with_hold && n == items / 2) hold_until_drained();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        x = (tgt_w_q > 1 && $urandom_range(0, 4) != 0) ? 9'($urandom_range(0, tgt_w_q - 1))
                                                        : 9'($urandom);
        y = (tgt_h_q > 1 && $urandom_range(0, 4) != 0) ? 8'($urandom_range(0, tgt_h_q - 1))
                                                        : 8'($urandom);
        render_pixel(x, y);
      end else if (r < 85) begin
        addr = (area > 0 && $urandom_range(0, 1) != 0) ?
               17'($urandom_range(0, 32'(area - 1))) : 17'($urandom);
        load_texel(addr, 8'($urandom));
      end else if (r < 95) begin
        addr = ($urandom_range(0, 4) != 0) ?
               17'($urandom_range(0, sct_pkg::PALETTE_DEPTH - 1)) :
               17'($urandom_range(sct_pkg::PALETTE_DEPTH, 131071));
        load_palette(addr, $urandom);
      end else begin
        send_word(OP_UNUSED, 17'($urandom), $urandom, 8'($urandom), 9'($urandom),
                  8'($urandom));
      end
    end
  endtask

  task automatic test_back_to_back();
    wait_idle();
    quiet = 1'b1;
    test_random_traffic(60, 1'b0);
    wait_idle();
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left = 0;
    end else if (quiet) begin
      sink_ready <= 1'b1;
    end else if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      sink_ready <= 1'b1;
      stall_left = pick_idle();
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word: translated_index %0d pixel_rgba %h",
               pix_ch.translated_index, pix_ch.pixel_rgba);
        err_count++;
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        if (pix_ch.translated_index !== oldest_pixel.index) begin
          $error("translated_index: expected %0d actual %0d", oldest_pixel.index,
                 pix_ch.translated_index);
          err_count++;
        end
        if (pix_ch.pixel_rgba !== oldest_pixel.rgba) begin
          $error("pixel_rgba: expected %h actual %h", oldest_pixel.rgba, pix_ch.pixel_rgba);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((cmd_ch.valid && cmd_ch.ready) || (pix_ch.valid && pix_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.operation <= sct_pkg::OP_LOAD_PALETTE;
    cmd_ch.load_address <= '0;
    cmd_ch.palette_word <= '0;
    cmd_ch.texel_value <= '0;
    cmd_ch.pixel_x <= '0;
    cmd_ch.pixel_y <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= sct_pkg::REG_TOP_COLOR;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_color_ranges();
    test_scaling_extremes();
    test_random_traffic(80, 1'b0);
    test_random_traffic(80, 1'b1);
    test_back_to_back();
    test_random_traffic(80, 1'b0);
    test_random_traffic(80, 1'b0);
    test_random_traffic(80, 1'b1);
    wait_idle();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sct_pkg.sv
rtl/sct_if.sv
rtl/sct_ram.sv
rtl/sct_div.sv
rtl/skin_color_translate_scaler.sv
rtl/sct_check.sv
tb/sv/tb_skin_color_translate_scaler.sv
